>>> rtl/mwa_pkg.sv
// shared definitions for the mirrored window average block
// no dependencies
package mwa_pkg;

    localparam int MAX_HALF_WINDOW = 15;
    localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW + 1;
    localparam int ADDR_W          = $clog2(WIN_DEPTH + 1);
    localparam int SCORE_W         = 16;
    localparam int COUNT_W         = 16;
    localparam int HALF_W          = 4;
    localparam int SUM_W           = SCORE_W + $clog2(WIN_DEPTH + 1);
    localparam int DIVISOR_W       = $clog2(WIN_DEPTH + 1);
    localparam int DIV_CNT_W       = $clog2(SUM_W + 1);
    localparam int TAP_W           = $clog2(WIN_DEPTH + 1);
    localparam int POS_W           = COUNT_W + 3;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WINDOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } mwa_state_t;

endpackage

>>> rtl/mirrored_window_average.sv
// top level of the mirrored window average block
// depends on mwa_pkg
//
// Centered moving average with mirrored edges over a run of column_count
// scores. Each accepted score is written into a 32-entry synchronous score
// memory; every result then sweeps 2*h+1 taps of that memory one tap a
// cycle, collects the last read in a drain step, divides the sum by 2*h+1
// in a radix-2 divider and hands the mean to the output register. The final
// input of a run flushes up to h+1 results, the last marked by tlast. While
// a result sits in the output register, the next result is already being
// computed. When half_window is above column_count/4 each input is passed
// through unaveraged with tuser set. Configuration writes are taken in every
// cycle and must be made while the block is idle.
module mirrored_window_average (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mwa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mwa_pkg::COUNT_W-1:0]       cfg_data,
    // input scores
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // score_in
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // window_mean, column_index
    output logic                              m_tlast,   // run_last
    output logic                              m_tuser    // rejected
);
    import mwa_pkg::*;

    mwa_state_t               state_reg, state_next;
    logic [HALF_W-1:0]        half_window_reg, half_window_next;
    logic [COUNT_W-1:0]       column_count_reg, column_count_next;
    logic [COUNT_W-1:0]       received_count_reg, received_count_next;
    logic [ADDR_W-1:0]        wp_reg, wp_next;
    logic [COUNT_W-1:0]       p_reg, p_next;
    logic [HALF_W-1:0]        h_reg, h_next;
    logic                     last_reg, last_next;
    logic                     rej_reg, rej_next;
    logic [COUNT_W-1:0]       i_reg, i_next;
    logic [COUNT_W-1:0]       i_end_reg, i_end_next;
    logic [TAP_W-1:0]         k_reg, k_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [DIVISOR_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [SCORE_W-1:0]       mean_reg, mean_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [31:0]              m_tdata_reg, m_tdata_next;
    logic                     m_tlast_reg, m_tlast_next;
    logic                     m_tuser_reg, m_tuser_next;

    // score memory
    logic [SCORE_W-1:0]       mem [0:(1 << ADDR_W)-1];
    logic [SCORE_W-1:0]       mem_rdata_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;

    // accept-time decode
    logic [COUNT_W-1:0]       count_eff;
    logic                     in_last;
    logic                     in_rej;
    logic                     has_result;
    logic [COUNT_W-1:0]       start_idx;
    logic [COUNT_W-1:0]       end_idx;

    // tap address generation
    logic signed [POS_W-1:0]  p_s, j_s, m_s, d_s;
    logic                     tap_ok;
    logic [DIVISOR_W-1:0]     divisor;
    logic [DIVISOR_W:0]       trial;
    logic                     out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        count_eff  = (column_count_reg == '0) ? COUNT_W'(1) : column_count_reg;
        in_last    = ({1'b0, received_count_reg} + (COUNT_W+1)'(1)) >= {1'b0, count_eff};
        in_rej     = COUNT_W'(half_window_reg) > (count_eff >> 2);
        has_result = (received_count_reg >= COUNT_W'(half_window_reg)) || in_last;
        start_idx  = (received_count_reg >= COUNT_W'(half_window_reg))
                   ? received_count_reg - COUNT_W'(half_window_reg) : '0;
        end_idx    = in_last ? received_count_reg
                   : received_count_reg - COUNT_W'(half_window_reg);
    end

    always_comb
    begin
        p_s    = $signed({3'b000, p_reg});
        j_s    = $signed({3'b000, i_reg}) - $signed(POS_W'(h_reg))
               + $signed(POS_W'(k_reg));
        if (j_s < 0)
        begin
            m_s = -j_s;
        end
        else if (j_s > p_s)
        begin
            m_s = (p_s <<< 1) - j_s;
        end
        else
        begin
            m_s = j_s;
        end
        d_s       = p_s - m_s;
        tap_ok    = (m_s >= 0) && (m_s <= p_s) && (d_s < $signed(POS_W'(WIN_DEPTH)));
        mem_raddr = wp_reg - d_s[ADDR_W-1:0];
        divisor   = {h_reg, 1'b1};
        trial     = {rem_reg, sum_reg[SUM_W-1]};
        out_free  = !m_tvalid_reg || m_tready;
    end

    always_comb
    begin
        state_next          = state_reg;
        half_window_next    = half_window_reg;
        column_count_next   = column_count_reg;
        received_count_next = received_count_reg;
        wp_next             = wp_reg;
        p_next              = p_reg;
        h_next              = h_reg;
        last_next           = last_reg;
        rej_next            = rej_reg;
        i_next              = i_reg;
        i_end_next          = i_end_reg;
        k_next              = k_reg;
        rd_valid_next       = 1'b0;
        sum_next            = sum_reg;
        rem_next            = rem_reg;
        div_cnt_next        = div_cnt_reg;
        mean_next           = mean_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;
        m_tlast_next        = m_tlast_reg;
        m_tuser_next        = m_tuser_reg;
        mem_we              = 1'b0;
        mem_waddr           = wp_reg + ADDR_W'(1);
        mem_re              = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HALF_WINDOW:  half_window_next  = cfg_data[HALF_W-1:0];
                REG_COLUMN_COUNT: column_count_next = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mem_we              = 1'b1;
                    wp_next             = wp_reg + ADDR_W'(1);
                    p_next              = received_count_reg;
                    h_next              = half_window_reg;
                    last_next           = in_last;
                    rej_next            = in_rej;
                    received_count_next = in_last ? '0 : received_count_reg + COUNT_W'(1);
                    k_next              = '0;
                    sum_next            = '0;
                    if (in_rej)
                    begin
                        i_next     = received_count_reg;
                        i_end_next = received_count_reg;
                        mean_next  = s_tdata;
                        state_next = ST_OUT;
                    end
                    else if (has_result)
                    begin
                        i_next     = start_idx;
                        i_end_next = end_idx;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                sum_next      = sum_reg + (rd_valid_reg ? SUM_W'(mem_rdata_reg) : '0);
                mem_re        = tap_ok;
                rd_valid_next = tap_ok;
                k_next        = k_reg + TAP_W'(1);
                if (k_reg == {h_reg, 1'b0})
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                sum_next     = sum_reg + (rd_valid_reg ? SUM_W'(mem_rdata_reg) : '0);
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, quotient bits shift into the sum register
                if (trial >= {1'b0, divisor})
                begin
                    rem_next = DIVISOR_W'(trial - {1'b0, divisor});
                    sum_next = {sum_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DIVISOR_W-1:0];
                    sum_next = {sum_reg[SUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rej_reg ? mean_reg : sum_reg[SCORE_W-1:0], i_reg};
                    m_tlast_next  = last_reg && (i_reg == p_reg);
                    m_tuser_next  = rej_reg;
                    if (i_reg == i_end_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + COUNT_W'(1);
                        k_next     = '0;
                        sum_next   = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            half_window_reg    <= '0;
            column_count_reg   <= COUNT_W'(1);
            received_count_reg <= '0;
            wp_reg             <= '0;
            rd_valid_reg       <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            half_window_reg    <= half_window_next;
            column_count_reg   <= column_count_next;
            received_count_reg <= received_count_next;
            wp_reg             <= wp_next;
            rd_valid_reg       <= rd_valid_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        h_reg       <= h_next;
        last_reg    <= last_next;
        rej_reg     <= rej_next;
        i_reg       <= i_next;
        i_end_reg   <= i_end_next;
        k_reg       <= k_next;
        sum_reg     <= sum_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        mean_reg    <= mean_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= s_tdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // a memory read is only collected right after a tap cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SUM))
        else $error("read data flagged outside the tap sweep");

    // the tap counter never runs past the window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (k_reg <= {h_reg, 1'b0}))
        else $error("tap counter beyond window");

    // a new score is only taken when no result is being computed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_DIV) && !rd_valid_reg)
        else $error("score accepted while a result was in progress");

endmodule
